FILE: rtl/adsr_envelope_amplitude_macros.svh
// Assertion helpers for the checker.
`ifndef ADSR_ENVELOPE_AMPLITUDE_MACROS_SVH
`define ADSR_ENVELOPE_AMPLITUDE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ADSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ADSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/adsr_pkg.sv
package adsr_pkg;

    // Default widths of tick and level values
    localparam int TIME_BITS_DEF  = 32;
    localparam int LEVEL_BITS_DEF = 16;

    // Register widths
    localparam int DUR_W      = 24;
    localparam int CFG_LVL_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DUR_W;

    // Register reset values
    localparam logic [DUR_W-1:0]     ATTACK_RST  = 24'd441;
    localparam logic [DUR_W-1:0]     DECAY_RST   = 24'd44100;
    localparam logic [DUR_W-1:0]     RELEASE_RST = 24'd44100;
    localparam logic [CFG_LVL_W-1:0] PEAK_RST    = 16'd32768;
    localparam logic [CFG_LVL_W-1:0] SUSTAIN_RST = 16'd0;

    // Levels at or below full scale / TINY_DIV read as silence
    localparam int TINY_DIV = 10000;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_DECAY   = 3'd1,
        CFG_RELEASE = 3'd2,
        CFG_PEAK    = 3'd3,
        CFG_SUSTAIN = 3'd4
    } t_cfg_idx;

    // Envelope segment of the held level that the back end evaluates
    typedef enum logic [1:0] {
        PH_SILENT,
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN
    } t_phase;

    // Effective durations (zero acts as one) and attack plus decay
    typedef struct packed {
        logic [DUR_W-1:0] a;
        logic [DUR_W-1:0] d;
        logic [DUR_W-1:0] r;
        logic [DUR_W:0]   ad;
    } t_dur;

    // One classified word waiting for the back end
    typedef struct packed {
        t_phase           phase;
        logic [DUR_W-1:0] x;
        logic [DUR_W-1:0] s2;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [DUR_W-1:0] dur_eff(input logic [DUR_W-1:0] v);
        return (v == '0) ? DUR_W'(1) : v;
    endfunction

endpackage

FILE: rtl/adsr_envelope_amplitude.sv
// Throughput: one word per cycle while the output is not stalled; set by the two restoring dividers,
// each resolving one quotient bit per pipeline stage.
// A 4-entry queue decouples the classifying front end from the divider back end.
// Reset (synchronous, active low) empties the pipeline and queue and loads the
// default envelope registers; no clearing pass is needed.
module adsr_envelope_amplitude #(
    parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [TIME_BITS-1:0]            i_now_tick,
    input  logic [TIME_BITS-1:0]            i_on_tick,
    input  logic [TIME_BITS-1:0]            i_off_tick,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [LEVEL_BITS-1:0]           o_level,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DW = adsr_pkg::DUR_W;
    localparam int VW = adsr_pkg::CFG_LVL_W;
    localparam int LB = LEVEL_BITS;
    localparam logic [LB-1:0] ONE = LB'(1) << (LB - 1);

    logic [DW-1:0] r_attack;
    logic [DW-1:0] r_decay;
    logic [DW-1:0] r_release;
    logic [VW-1:0] r_peak;
    logic [VW-1:0] r_sustain;
    logic [DW:0]   r_ad_sum;

    adsr_pkg::t_dur   w_dur;
    adsr_pkg::t_qent  w_ent;
    adsr_pkg::t_qent  w_head;
    adsr_pkg::t_qstat w_qstat;
    logic             w_push;
    logic             w_pop;
    logic [LB-1:0]    w_pk_m;
    logic [LB-1:0]    w_su_m;
    logic [LB-1:0]    w_pk;
    logic [LB-1:0]    w_su;

    assign o_cfg_ready = 1'b1;

    // Write envelope registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= adsr_pkg::ATTACK_RST;
            r_decay   <= adsr_pkg::DECAY_RST;
            r_release <= adsr_pkg::RELEASE_RST;
            r_peak    <= adsr_pkg::PEAK_RST;
            r_sustain <= adsr_pkg::SUSTAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                adsr_pkg::CFG_ATTACK:  r_attack  <= i_cfg_data;
                adsr_pkg::CFG_DECAY:   r_decay   <= i_cfg_data;
                adsr_pkg::CFG_RELEASE: r_release <= i_cfg_data;
                adsr_pkg::CFG_PEAK:    r_peak    <= i_cfg_data[VW-1:0];
                adsr_pkg::CFG_SUSTAIN: r_sustain <= i_cfg_data[VW-1:0];
                default:               r_attack  <= r_attack;
            endcase
        end
    end

    // Precompute end of decay
    always_ff @(posedge i_clk) begin
        r_ad_sum <= {1'b0, adsr_pkg::dur_eff(r_attack)} + {1'b0, adsr_pkg::dur_eff(r_decay)};
    end

    always_comb begin
        w_dur.a  = adsr_pkg::dur_eff(r_attack);
        w_dur.d  = adsr_pkg::dur_eff(r_decay);
        w_dur.r  = adsr_pkg::dur_eff(r_release);
        w_dur.ad = r_ad_sum;
        // Saturate levels to full scale
        w_pk_m   = LB'(r_peak);
        w_su_m   = LB'(r_sustain);
        w_pk     = (w_pk_m > ONE) ? ONE : w_pk_m;
        w_su     = (w_su_m > ONE) ? ONE : w_su_m;
    end

    adsr_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_now_tick (i_now_tick),
        .i_on_tick  (i_on_tick),
        .i_off_tick (i_off_tick),
        .i_dur      (w_dur),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_ent      (w_ent)
    );

    adsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_ent),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    adsr_back #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_dur       (w_dur),
        .i_peak      (w_pk),
        .i_sustain   (w_su),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_level     (o_level)
    );

endmodule

FILE: rtl/adsr_front.sv
module adsr_front #(
    parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [TIME_BITS-1:0]   i_now_tick,
    input  logic [TIME_BITS-1:0]   i_on_tick,
    input  logic [TIME_BITS-1:0]   i_off_tick,
    input  adsr_pkg::t_dur         i_dur,
    input  adsr_pkg::t_qstat       i_qstat,
    output logic                   o_push,
    output adsr_pkg::t_qent        o_ent
);

    localparam int DW = adsr_pkg::DUR_W;
    localparam int CW = (TIME_BITS > DW + 1) ? TIME_BITS : DW + 1;

    logic                 r_valid;
    logic                 r_held;
    logic                 r_neg;
    logic [TIME_BITS-1:0] r_t;
    logic [TIME_BITS-1:0] r_since;

    logic                 w_accept;
    logic                 w_held;
    logic [TIME_BITS:0]   w_life;
    logic [TIME_BITS:0]   w_since;
    logic [TIME_BITS-1:0] w_dko;
    logic [CW-1:0]        w_t;
    logic [CW-1:0]        w_a;
    logic [CW-1:0]        w_ad;
    logic [CW-1:0]        w_r;
    logic [CW-1:0]        w_sc;
    logic [CW-1:0]        w_u;
    logic                 w_late;

    // Hold the input while the staged word cannot move into the queue
    assign o_in_stall = r_valid && i_qstat.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_qstat.full;

    // Take the time differences of the incoming word
    always_comb begin
        w_held  = i_on_tick > i_off_tick;
        w_life  = {1'b0, i_now_tick} - {1'b0, i_on_tick};
        w_since = {1'b0, i_now_tick} - {1'b0, i_off_tick};
        w_dko   = i_off_tick - i_on_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Stage the time since key-on (held) or key-on to key-off (released)
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held  <= w_held;
            r_neg   <= w_held ? w_life[TIME_BITS] : w_since[TIME_BITS];
            r_t     <= w_held ? w_life[TIME_BITS-1:0] : w_dko;
            r_since <= w_since[TIME_BITS-1:0];
        end
    end

    // Classify the envelope segment
    always_comb begin
        w_t    = CW'(r_t);
        w_a    = CW'(i_dur.a);
        w_ad   = CW'(i_dur.ad);
        w_r    = CW'(i_dur.r);
        w_sc   = CW'(r_since);
        w_u    = w_t - w_a;
        w_late = !r_held && (w_sc > w_r);

        o_ent.phase = adsr_pkg::PH_SUSTAIN;
        o_ent.x     = '0;
        o_ent.s2    = r_held ? '0 : DW'(r_since);
        if (r_neg || w_late) begin
            o_ent.phase = adsr_pkg::PH_SILENT;
            o_ent.s2    = '0;
        end else if (w_t <= w_a) begin
            o_ent.phase = adsr_pkg::PH_ATTACK;
            o_ent.x     = DW'(r_t);
        end else if (w_t <= w_ad) begin
            o_ent.phase = adsr_pkg::PH_DECAY;
            o_ent.x     = DW'(w_u);
        end
    end

endmodule

FILE: rtl/adsr_queue.sv
module adsr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  adsr_pkg::t_qent   i_ent,
    input  logic              i_pop,
    output adsr_pkg::t_qent   o_head,
    output adsr_pkg::t_qstat  o_qstat
);

    localparam int DEPTH = adsr_pkg::Q_DEPTH;
    localparam int AW    = adsr_pkg::Q_AW;
    localparam int NW    = AW + 1;

    adsr_pkg::t_qent r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [NW-1:0]   r_cnt;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == NW'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

endmodule

FILE: rtl/adsr_muldiv.sv
// Pipelined base +/- floor(x * y / div); needs x <= div and div != 0.
module adsr_muldiv #(
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [adsr_pkg::DUR_W-1:0] i_x,
    input  logic [LEVEL_BITS-1:0]   i_y,
    input  logic [adsr_pkg::DUR_W-1:0] i_div,
    input  logic [LEVEL_BITS-1:0]   i_base,
    input  logic                    i_sub,
    output logic                    o_valid,
    output logic [LEVEL_BITS-1:0]   o_res
);

    localparam int DW = adsr_pkg::DUR_W;
    localparam int LB = LEVEL_BITS;
    localparam int PW = DW + LB;

    logic [PW-1:0] w_prod;
    logic [DW:0]   w_t  [LB];
    logic          w_ge [LB];

    // Remainder and numerator bits still to shift in; quotient fills from the bottom
    logic [DW-1:0] r_rem  [LB];
    logic [DW-1:0] r_div  [LB];
    logic [LB-1:0] r_ql   [LB+1];
    logic [LB-1:0] r_base [LB+1];
    logic          r_sub  [LB+1];
    logic          r_v    [LB+1];
    logic          r_ov;
    logic [LB-1:0] r_res;

    assign w_prod = i_x * i_y;

    // One restoring step per stage
    always_comb begin
        for (int j = 0; j < LB; j++) begin
            w_t[j]  = {r_rem[j], r_ql[j][LB-1]};
            w_ge[j] = w_t[j] >= {1'b0, r_div[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= LB; j++) begin
                r_v[j] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j <= LB; j++) begin
                r_v[j] <= r_v[j-1];
            end
            r_ov <= r_v[LB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Register the product; its upper part is already below div
            r_rem[0]  <= w_prod[PW-1:LB];
            r_ql[0]   <= w_prod[LB-1:0];
            r_div[0]  <= i_div;
            r_base[0] <= i_base;
            r_sub[0]  <= i_sub;
            for (int j = 0; j < LB; j++) begin
                r_ql[j+1]   <= {r_ql[j][LB-2:0], w_ge[j]};
                r_base[j+1] <= r_base[j];
                r_sub[j+1]  <= r_sub[j];
            end
            for (int j = 0; j < LB - 1; j++) begin
                r_rem[j+1] <= w_ge[j] ? DW'(w_t[j] - {1'b0, r_div[j]}) : w_t[j][DW-1:0];
                r_div[j+1] <= r_div[j];
            end
            // Apply the quotient to the base level
            r_res <= r_sub[LB] ? (r_base[LB] - r_ql[LB]) : (r_base[LB] + r_ql[LB]);
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

FILE: rtl/adsr_back.sv
module adsr_back #(
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  adsr_pkg::t_qstat      i_qstat,
    input  adsr_pkg::t_qent       i_head,
    output logic                  o_pop,
    input  adsr_pkg::t_dur        i_dur,
    input  logic [LEVEL_BITS-1:0] i_peak,
    input  logic [LEVEL_BITS-1:0] i_sustain,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [LEVEL_BITS-1:0] o_level
);

    localparam int DW  = adsr_pkg::DUR_W;
    localparam int LB  = LEVEL_BITS;
    localparam int LAT = LB + 2;
    localparam logic [LB-1:0] ONE = LB'(1) << (LB - 1);
    localparam int unsigned TINY_I = (2 ** (LB - 1)) / adsr_pkg::TINY_DIV;
    localparam logic [LB-1:0] TINY = LB'(TINY_I);

    logic          w_adv;
    logic [DW-1:0] w_x1;
    logic [DW-1:0] w_div1;
    logic [LB-1:0] w_y1;
    logic [LB-1:0] w_base1;
    logic          w_sub1;
    logic          w_v1;
    logic          w_v2;
    logic [LB-1:0] w_h;
    logic [LB-1:0] w_amp;
    logic [LB-1:0] w_lvl;

    logic [DW-1:0] r_s2 [LAT];
    logic          r_out_valid;
    logic [LB-1:0] r_level;

    // Freeze the whole back end while the output word is stalled
    assign w_adv = !(r_out_valid && i_out_stall);
    assign o_pop = w_adv && !i_qstat.empty;

    // Pick operands of the held-level step from the segment
    always_comb begin
        w_x1    = '0;
        w_y1    = '0;
        w_div1  = i_dur.a;
        w_base1 = '0;
        w_sub1  = 1'b0;
        case (i_head.phase)
            adsr_pkg::PH_ATTACK: begin
                w_x1 = i_head.x;
                w_y1 = i_peak;
            end
            adsr_pkg::PH_DECAY: begin
                w_x1    = i_head.x;
                w_div1  = i_dur.d;
                w_base1 = i_peak;
                if (i_peak >= i_sustain) begin
                    w_y1   = i_peak - i_sustain;
                    w_sub1 = 1'b1;
                end else begin
                    w_y1 = i_sustain - i_peak;
                end
            end
            adsr_pkg::PH_SUSTAIN: begin
                w_base1 = i_sustain;
            end
            default: begin
                w_base1 = '0;
            end
        endcase
    end

    // Carry release time alongside the first step
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2[0] <= i_head.s2;
            for (int k = 1; k < LAT; k++) begin
                r_s2[k] <= r_s2[k-1];
            end
        end
    end

    adsr_muldiv #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_held (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (o_pop),
        .i_x     (w_x1),
        .i_y     (w_y1),
        .i_div   (w_div1),
        .i_base  (w_base1),
        .i_sub   (w_sub1),
        .o_valid (w_v1),
        .o_res   (w_h)
    );

    // Release: level minus its share of elapsed release time
    adsr_muldiv #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_release (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_v1),
        .i_x     (r_s2[LAT-1]),
        .i_y     (w_h),
        .i_div   (i_dur.r),
        .i_base  (w_h),
        .i_sub   (1'b1),
        .o_valid (w_v2),
        .o_res   (w_amp)
    );

    // Clamp to full scale and drop tiny levels
    always_comb begin
        if (w_amp > ONE) begin
            w_lvl = ONE;
        end else if (w_amp <= TINY) begin
            w_lvl = '0;
        end else begin
            w_lvl = w_amp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_level <= w_lvl;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_level;

endmodule

FILE: rtl/adsr_checker.sv
`include "adsr_envelope_amplitude_macros.svh"

module adsr_checker #(
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_stall,
    input logic                  i_out_valid,
    input logic                  i_out_stall,
    input logic [LEVEL_BITS-1:0] i_level
);

    localparam int LB = LEVEL_BITS;
    localparam logic [LB-1:0] ONE = LB'(1) << (LB - 1);
    localparam int unsigned TINY_I = (2 ** (LB - 1)) / adsr_pkg::TINY_DIV;
    localparam logic [LB-1:0] TINY = LB'(TINY_I);
    localparam int CNT_W = $clog2(adsr_pkg::Q_DEPTH + 2 * LEVEL_BITS + 8) + 1;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = i_in_valid && !i_in_stall;
    assign w_out_acc = i_out_valid && !i_out_stall;

    // Track words in flight
    always_comb begin
        n_cnt = r_cnt;
        if (w_in_acc) begin
            n_cnt = n_cnt + CNT_W'(1);
        end
        if (w_out_acc) begin
            n_cnt = n_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `ADSR_ASSERT_IMPL(a_level_range, i_clk, i_rst_n, i_out_valid, i_level <= ONE, "level above full scale")
    `ADSR_ASSERT_IMPL(a_level_floor, i_clk, i_rst_n, i_out_valid, (i_level == '0) || (i_level > TINY), "tiny level not squashed")
    `ADSR_ASSERT_IMPL(a_no_phantom, i_clk, i_rst_n, i_out_valid, r_cnt != '0, "output word with no input word in flight")
    `ADSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_level), "stalled output word changed")

endmodule

bind adsr_envelope_amplitude adsr_checker #(
    .LEVEL_BITS (LEVEL_BITS)
) u_adsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_level     (o_level)
);
